// ===== src/twhl_pkg.sv =====
// Shared types and codes for the time-window history lookback unit.
package twhl_pkg;

	localparam int TWHL_DEPTH = 64;
	localparam int TIME_W = 48;
	localparam int SPAN_W = 47;
	localparam int VAL_W = 64;
	localparam int STATUS_W = 3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKBACK = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_BEYOND = 3'd1,
		ST_EMPTY = 3'd2,
		ST_DISABLED = 3'd3,
		ST_DUPLICATE = 3'd4,
		ST_DROPPED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_EVICT,
		CMD_INSERT
	} cell_cmd_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_cmd_t cmd;
		logic signed [TIME_W-1:0] key_time;
		logic [VAL_W-1:0] key_val;
		logic [SPAN_W-1:0] span;
		logic any_eq;
		logic any_lt;
		logic oldest_ok;
	} cell_ctrl_t;

	// Handed from cell i to cell i+1 (toward older entries).
	typedef struct packed {
		logic head;
		logic valid;
		logic gt;
		logic ge;
		logic surv;
		logic signed [TIME_W-1:0] tstamp;
		logic [VAL_W-1:0] val;
	} cell_link_t;

	localparam cell_link_t HEAD_LINK = '{
		head: 1'b1, valid: 1'b0, gt: 1'b1, ge: 1'b1, surv: 1'b0,
		tstamp: '0, val: '0
	};

endpackage

// ===== src/twhl_cell.sv =====
// One cell of the sorted history chain: a (time, value) entry, its compares and shift logic.
module twhl_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tail,
	input  twhl_pkg::cell_ctrl_t   ctrl,
	input  twhl_pkg::cell_link_t   prev_link,
	input  logic                   next_valid,
	input  logic                   next_take_up,
	output twhl_pkg::cell_link_t   link,
	output logic                   take_up,
	output logic                   eq,
	output logic                   lt,
	output logic                   sel
);
	import twhl_pkg::*;

	logic                      valid_q;
	logic signed [TIME_W-1:0]  tstamp_q;
	logic [VAL_W-1:0]          val_q;

	logic signed [TIME_W:0]    t_ext;
	logic signed [TIME_W:0]    reach;
	logic signed [TIME_W:0]    pair_sum;
	logic signed [TIME_W:0]    twice_t;
	logic                      gt;
	logic                      surv;
	logic                      boundary;
	logic                      pick_lo;
	logic                      last;
	logic                      keep;

	assign t_ext    = {ctrl.key_time[TIME_W-1], ctrl.key_time};
	assign reach    = {tstamp_q[TIME_W-1], tstamp_q} + $signed({2'b00, ctrl.span});
	assign pair_sum = {tstamp_q[TIME_W-1], tstamp_q}
		+ {prev_link.tstamp[TIME_W-1], prev_link.tstamp};
	assign twice_t  = {ctrl.key_time, 1'b0};

	assign gt   = valid_q && (tstamp_q > ctrl.key_time);
	assign eq   = valid_q && (tstamp_q == ctrl.key_time);
	assign lt   = valid_q && (tstamp_q < ctrl.key_time);
	assign surv = valid_q && !(reach < t_ext);

	// Lookback: the boundary cell is the newest entry older than the query.
	assign boundary = lt && prev_link.ge;
	assign pick_lo  = prev_link.head || (twice_t < pair_sum);
	assign take_up  = boundary && !pick_lo;
	assign last     = valid_q && !next_valid;
	assign sel      = eq || (!ctrl.any_eq && ((boundary && pick_lo) || next_take_up
		|| (last && !ctrl.any_lt && ctrl.oldest_ok)));

	assign link = '{head: 1'b0, valid: valid_q, gt: gt, ge: valid_q && !lt, surv: surv,
		tstamp: tstamp_q, val: val_q};

	// The last cell never keeps on insert: a full chain pushes its entry out.
	assign keep = gt && !tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				CMD_EVICT: begin
					valid_q <= surv;
				end
				CMD_INSERT: begin
					if (keep) begin
						valid_q <= surv;
					end else if (prev_link.gt) begin
						valid_q <= 1'b1;
					end else begin
						valid_q <= prev_link.surv;
					end
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd == CMD_INSERT && !keep) begin
			if (prev_link.gt) begin
				tstamp_q <= ctrl.key_time;
				val_q    <= ctrl.key_val;
			end else begin
				tstamp_q <= prev_link.tstamp;
				val_q    <= prev_link.val;
			end
		end
	end

endmodule

// ===== src/time_window_history_lookback_unit.sv =====
// Top level of the time-window history lookback unit: cell chain, control and result register.
//
// The unit keeps up to DEPTH (time, value) samples in a chain of cells sorted from
// newest (cell 0) to oldest, and answers two kinds of request words. An insert evicts
// every sample whose time plus window_span lies below the new time, then places the
// new pair in order by shifting older samples one cell down the chain; a duplicate time
// keeps the stored value, a zero span disables inserts, and when the chain is full the
// oldest sample falls off the end and the result says so. A lookback returns the exact
// match, the oldest sample when the query is older than every sample but not older than
// now_time minus window_span, the newest sample when the query is newer than all of them,
// or else the nearer neighbor with ties going to the later one. Every request word yields
// exactly one result word (value_out, status). For an insert, all cells compare against the
// new time and shift at the same clock edge, so a new insert can be taken every cycle
// while the result register is not stalled. For a lookback, the accepting edge registers
// each cell's one-hot pick; then the picked value is gathered across all DEPTH cells into
// the result register, and in_stall is high while it gathers. The result sits in an output
// register, so a new word is accepted while a finished result waits, but not while that
// register is full and stalled. window_span is written through the cfg port; the user must
// do so only while the unit is idle (not enforced by the block); cfg_ready is always high.
module time_window_history_lookback_unit #(
	parameter int DEPTH = twhl_pkg::TWHL_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [twhl_pkg::SPAN_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [twhl_pkg::TIME_W-1:0]   sample_time,
	input  logic [twhl_pkg::VAL_W-1:0]           sample_value,
	input  logic signed [twhl_pkg::TIME_W-1:0]   now_time,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [twhl_pkg::VAL_W-1:0]           value_out,
	output logic [twhl_pkg::STATUS_W-1:0]        status
);
	import twhl_pkg::*;

	logic [SPAN_W-1:0]    span_q;
	logic                 look_s1;
	logic [DEPTH-1:0]     sel_s1;
	status_t              look_st_s1;
	logic                 out_valid_q;
	logic [VAL_W-1:0]     value_q;
	status_t              status_q;

	cell_ctrl_t           ctrl;
	cell_link_t           links [DEPTH];
	logic [DEPTH-1:0]     cell_valid;
	logic [DEPTH-1:0]     take_up;
	logic [DEPTH-1:0]     eq_vec;
	logic [DEPTH-1:0]     lt_vec;
	logic [DEPTH-1:0]     sel_vec;

	logic                 accept;
	logic                 is_insert;
	logic                 span_zero;
	logic                 any_eq;
	logic                 any_lt;
	logic                 beyond;
	logic signed [TIME_W:0] floor_time;
	logic [VAL_W-1:0]     gathered;
	status_t              insert_st;
	status_t              look_st;

	// The configuration register is always ready to take a word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			span_q <= cfg_data;
		end
	end

	// New words wait while a lookback gathers its value or the result register is blocked.
	assign in_stall  = look_s1 || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign is_insert = (req_type == REQ_INSERT);
	assign span_zero = (span_q == '0);

	assign any_eq = |eq_vec;
	assign any_lt = |lt_vec;

	// Oldest-sample window: the query must not lie below now_time minus the span.
	assign floor_time = {now_time[TIME_W-1], now_time} - $signed({2'b00, span_q});
	assign beyond     = ($signed({sample_time[TIME_W-1], sample_time}) < floor_time);

	always_comb begin
		ctrl.key_time  = sample_time;
		ctrl.key_val   = sample_value;
		ctrl.span      = span_q;
		ctrl.any_eq    = any_eq;
		ctrl.any_lt    = any_lt;
		ctrl.oldest_ok = !beyond;
		ctrl.cmd       = CMD_HOLD;
		if (accept && is_insert && !span_zero) begin
			// A duplicate time still clears expired samples but adds nothing.
			ctrl.cmd = any_eq ? CMD_EVICT : CMD_INSERT;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			cell_link_t prev_l;
			logic       nxt_valid;
			logic       nxt_take;

			if (gi == 0) begin : g_first
				assign prev_l = HEAD_LINK;
			end else begin : g_mid
				assign prev_l = links[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign nxt_valid = 1'b0;
				assign nxt_take  = 1'b0;
			end else begin : g_inner
				assign nxt_valid = cell_valid[gi+1];
				assign nxt_take  = take_up[gi+1];
			end

			twhl_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.tail         (gi == DEPTH - 1),
				.ctrl         (ctrl),
				.prev_link    (prev_l),
				.next_valid   (nxt_valid),
				.next_take_up (nxt_take),
				.link         (links[gi]),
				.take_up      (take_up[gi]),
				.eq           (eq_vec[gi]),
				.lt           (lt_vec[gi]),
				.sel          (sel_vec[gi])
			);

			assign cell_valid[gi] = links[gi].valid;
		end
	endgenerate

	// Insert result: the last cell surviving eviction means the chain is full.
	always_comb begin
		priority if (span_zero) begin
			insert_st = ST_DISABLED;
		end else if (any_eq) begin
			insert_st = ST_DUPLICATE;
		end else if (links[DEPTH-1].surv) begin
			insert_st = ST_DROPPED;
		end else begin
			insert_st = ST_OK;
		end
	end

	always_comb begin
		priority if (!cell_valid[0]) begin
			look_st = ST_EMPTY;
		end else if (!any_eq && !any_lt && beyond) begin
			look_st = ST_BEYOND;
		end else begin
			look_st = ST_OK;
		end
	end

	// The cells hold still during the gather cycle, so the registered pick stays valid.
	always_comb begin
		gathered = '0;
		for (int i = 0; i < DEPTH; i++) begin
			gathered = gathered | ({VAL_W{sel_s1[i]}} & links[i].val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_s1 <= 1'b0;
		end else begin
			look_s1 <= accept && !is_insert;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_insert) begin
			sel_s1     <= sel_vec;
			look_st_s1 <= look_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && is_insert) || look_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_insert) begin
			value_q  <= '0;
			status_q <= insert_st;
		end else if (look_s1) begin
			value_q  <= gathered;
			status_q <= look_st_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;
	assign status    = status_q;

	// Nothing is taken in while a lookback is still gathering its value.
	assert property (@(posedge clk) disable iff (!arst_n) look_s1 |-> !accept)
		else $error("word accepted during lookback gather");

	// A lookback picks at most one cell.
	assert property (@(posedge clk) disable iff (!arst_n) look_s1 |-> $onehot0(sel_s1))
		else $error("lookback picked more than one cell");

	// Occupied cells always form an unbroken run from the newest end.
	assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("hole in the history chain");

	// A failed lookback returns a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		look_s1 && (look_st_s1 == ST_EMPTY || look_st_s1 == ST_BEYOND)
		|=> out_valid && value_out == '0)
		else $error("failed lookback returned a value");

endmodule

// ===== bench/tb_time_window_history_lookback_unit.sv =====
// Self-checking testbench for the time-window history lookback unit.
module tb_time_window_history_lookback_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import twhl_pkg::*;

	// Widest legal times and span, held sign-extended at 64 bits so that every sum the
	// store needs (time plus span, now minus span) is exact.
	localparam longint TIME_TOP = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint TIME_BOTTOM = -TIME_TOP - 1;
	localparam longint SPAN_ALL = 64'sh0000_7FFF_FFFF_FFFF;
	// One whole time unit in the 32-bit fraction format.
	localparam longint TICK = 64'sd1 << 32;

	// One request word as it appears on the input ports.
	typedef struct packed {
		logic req;
		logic signed [TIME_W-1:0] stime;
		logic [VAL_W-1:0] sval;
		logic signed [TIME_W-1:0] now;
	} req_word_t;

	// One result word: the looked-back value and the status code.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		status_t st;
	} answer_t;

	// A row of the directed table: either a window-span write or a request word. A row
	// whose answer is obvious carries it typed in; all others rely on the history model.
	typedef struct {
		bit is_cfg;
		req_word_t w;
		bit typed;
		answer_t ans;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SPAN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_INSERT;
	logic signed [TIME_W-1:0] sample_time = '0;
	logic [VAL_W-1:0] sample_value = '0;
	logic signed [TIME_W-1:0] now_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VAL_W-1:0] value_out;
	logic [STATUS_W-1:0] status;

	// Travels alongside the word on the input side: when set, the answer for the word
	// being offered is the typed-in one rather than the model's.
	bit word_typed = 1'b0;
	answer_t word_ans = '{value: '0, st: ST_OK};

	// The history model: sorted from oldest (index 0) to newest, like the block's store
	// seen from the other end.
	longint hist_t[TWHL_DEPTH];
	logic [VAL_W-1:0] hist_v[TWHL_DEPTH];
	int hist_n = 0;
	longint span_now = 0;

	// Results owed by the block, oldest first.
	answer_t answers_due[$];

	plan_row_t plan[$];
	int gap_pct = 0;
	int stall_pct = 0;
	longint clock_cur = 0;
	int n_sent = 0;
	int n_out = 0;
	int mismatches = 0;
	int n_ins = 0;
	int n_look = 0;
	int span_writes = 0;
	int st_tally[8];

	time_window_history_lookback_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.sample_time(sample_time),
		.sample_value(sample_value),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_out(value_out),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Removes the n oldest samples from the model.
	function automatic void history_drop(input int n);
		int i;
		if (n == 0 || n > hist_n)
			return;
		for (i = 0; i < hist_n - n; i++) begin
			hist_t[i] = hist_t[i + n];
			hist_v[i] = hist_v[i + n];
		end
		hist_n -= n;
	endfunction

	// Applies one accepted word to the model and works out the result it must produce.
	function automatic void history_apply(input req_word_t w, output answer_t a);
		longint t;
		longint now;
		int n;
		int pos;
		int i;
		a.value = '0;
		a.st = ST_OK;
		t = longint'($signed(w.stime));
		now = longint'($signed(w.now));
		if (w.req == REQ_INSERT) begin
			if (span_now == 0) begin
				a.st = ST_DISABLED;
				return;
			end
			// Age out everything that has fallen behind the window of the new time.
			n = 0;
			while (n < hist_n && hist_t[n] + span_now < t)
				n++;
			history_drop(n);
			pos = 0;
			while (pos < hist_n && hist_t[pos] < t)
				pos++;
			if (pos < hist_n && hist_t[pos] == t) begin
				a.st = ST_DUPLICATE;
				return;
			end
			// A full store loses its oldest sample, even when the new one would be older.
			if (hist_n >= TWHL_DEPTH) begin
				history_drop(1);
				a.st = ST_DROPPED;
				if (pos > 0)
					pos--;
			end
			for (i = hist_n; i > pos; i--) begin
				hist_t[i] = hist_t[i - 1];
				hist_v[i] = hist_v[i - 1];
			end
			hist_t[pos] = t;
			hist_v[pos] = w.sval;
			hist_n++;
		end else if (hist_n == 0) begin
			a.st = ST_EMPTY;
		end else begin
			pos = 0;
			while (pos < hist_n && hist_t[pos] < t)
				pos++;
			if (pos < hist_n && hist_t[pos] == t) begin
				a.value = hist_v[pos];
			end else if (pos == 0) begin
				// Older than every sample: served by the oldest only inside the window.
				if (t < now - span_now)
					a.st = ST_BEYOND;
				else
					a.value = hist_v[0];
			end else if (pos == hist_n) begin
				a.value = hist_v[hist_n - 1];
			end else if (t - hist_t[pos - 1] < hist_t[pos] - t) begin
				a.value = hist_v[pos - 1];
			end else begin
				// Nearer to the later neighbor, or exactly halfway.
				a.value = hist_v[pos];
			end
		end
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic longint clamp_time(input longint x);
		if (x > TIME_TOP)
			return TIME_TOP;
		if (x < TIME_BOTTOM)
			return TIME_BOTTOM;
		return x;
	endfunction

	function automatic void add_row(input bit is_cfg, input logic req, input longint t,
			input logic [63:0] v, input longint now, input bit typed,
			input logic [63:0] xv, input status_t xs);
		plan_row_t r;
		r.is_cfg = is_cfg;
		r.w.req = req;
		r.w.stime = t[TIME_W-1:0];
		r.w.sval = v;
		r.w.now = now[TIME_W-1:0];
		r.typed = typed;
		r.ans.value = xv;
		r.ans.st = xs;
		plan.push_back(r);
	endfunction

	// Builds one random word. Most words follow a running clock, so the store fills,
	// ages out and overflows the way it does in use; queries aim at stored times, at
	// midpoints between neighbors, past both ends and at the edge of the window. The rest
	// is noise over the full width of every field.
	function automatic req_word_t compose_word();
		req_word_t w;
		logic [63:0] r;
		longint t;
		longint nw;
		longint step;
		longint lo;
		longint unsigned d;
		int k;
		int p;
		w.sval = rand64();
		if ($urandom_range(0, 99) < 12) begin
			w.req = ($urandom_range(0, 9) < 7) ? REQ_LOOKBACK : REQ_INSERT;
			r = rand64();
			w.stime = r[TIME_W-1:0];
			r = rand64();
			w.now = r[TIME_W-1:0];
			return w;
		end
		step = longint'($urandom) + (longint'($urandom_range(0, 1)) << 32);
		nw = clock_cur;
		k = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < 55) begin
			w.req = REQ_INSERT;
			if (k == 0 && hist_n > 0) begin
				t = hist_t[$urandom_range(0, hist_n - 1)];
			end else if (k == 1) begin
				// A late sample, sometimes older than everything held.
				t = clock_cur - step * longint'($urandom_range(1, 40));
			end else begin
				clock_cur += step;
				t = clock_cur;
			end
		end else begin
			w.req = REQ_LOOKBACK;
			if ($urandom_range(0, 3) == 0)
				nw = clock_cur + step;
			if (hist_n == 0) begin
				t = clock_cur - step;
			end else if (k <= 2) begin
				t = hist_t[$urandom_range(0, hist_n - 1)];
			end else if (k <= 4 && hist_n > 1) begin
				p = $urandom_range(0, hist_n - 2);
				t = hist_t[p] + (hist_t[p + 1] - hist_t[p]) / 2
					+ longint'($urandom_range(0, 2)) - 1;
			end else if (k == 5) begin
				t = nw - span_now + longint'($urandom_range(0, 4)) - 2;
			end else if (k == 6) begin
				t = hist_t[hist_n - 1] + step;
			end else begin
				lo = hist_t[0] - step;
				d = longint'(hist_t[hist_n - 1] + step - lo);
				t = lo + longint'(rand64() % (d + 1));
			end
		end
		t = clamp_time(t);
		nw = clamp_time(nw);
		w.stime = t[TIME_W-1:0];
		w.now = nw[TIME_W-1:0];
		// Keep the running clock well inside the time range.
		if (clock_cur > (64'sd1 << 46))
			clock_cur = -(64'sd1 << 46);
		return w;
	endfunction

	// Offers one word, after a random gap now and then, and returns once it is taken.
	task automatic send_word(input req_word_t w, input bit typed, input answer_t ans);
		int gap;
		gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 19) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= w.req;
		sample_time <= w.stime;
		sample_value <= w.sval;
		now_time <= w.now;
		word_typed <= typed;
		word_ans <= ans;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// The span may only change while nothing is in flight, so the sender holds off
	// until every result it is owed has come back.
	task automatic write_span(input longint span);
		in_valid <= 1'b0;
		while (n_out < n_sent)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= span[SPAN_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		span_writes++;
	endtask

	// The receiver holds off in bursts at a rate the stimulus sets per phase.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Everything is sampled at the clock edge, before any of this edge's updates land,
	// so the model sees exactly what the block sees. Results are checked first, then a
	// span write, then a newly accepted word.
	always @(posedge clk) begin : scoreboard
		req_word_t w;
		answer_t got;
		answer_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_out++;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: value_out %h status %0d",
							value_out, status);
				end else begin
					due = answers_due.pop_front();
					if (value_out !== due.value || status !== due.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: value_out %h want %h, status %0d want %0d",
								n_out, value_out, due.value, status, due.st);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				span_now = longint'(cfg_data);
			if (in_valid && !in_stall) begin
				w.req = req_type;
				w.stime = sample_time;
				w.sval = sample_value;
				w.now = now_time;
				history_apply(w, got);
				if (word_typed)
					got = word_ans;
				answers_due.push_back(got);
				if (w.req == REQ_INSERT)
					n_ins++;
				else
					n_look++;
				st_tally[got.st]++;
			end
		end
	end

	// Hard stop for a block that hangs; far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		longint phase_span[$];
		int phase_gap[$];
		int phase_stall[$];
		int phase_items;
		int p;
		int i;
		answer_t none;
		none = '{value: '0, st: ST_OK};

		// Right after reset the store is empty and the span is zero.
		add_row(0, REQ_LOOKBACK, 0, 0, 0, 1, 0, ST_EMPTY);
		add_row(0, REQ_INSERT, 5 * TICK, 64'h1234, 0, 1, 0, ST_DISABLED);
		add_row(0, REQ_LOOKBACK, TIME_TOP, 0, TIME_BOTTOM, 1, 0, ST_EMPTY);
		// Widest span, times at both ends of the range.
		add_row(1, REQ_INSERT, 0, SPAN_ALL, 0, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, TIME_BOTTOM, '1, 0, 1, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TIME_BOTTOM, 0, TIME_BOTTOM, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, TIME_TOP, 0, TIME_TOP, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, TIME_TOP, 64'hAAAA_5555_AAAA_5555, 0, 1, 0, ST_DUPLICATE);
		add_row(0, REQ_LOOKBACK, TIME_TOP, '1, TIME_TOP, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TIME_BOTTOM, 0, TIME_BOTTOM, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TIME_BOTTOM, 0, TIME_TOP, 1, 0, ST_BEYOND);
		// Ten time units: neighbors, an exact tie, the window edge and aging out.
		add_row(1, REQ_INSERT, 0, 10 * TICK, 0, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, 0, 64'h0A, 0, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, 4 * TICK, 64'h0B, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, 2 * TICK, 0, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TICK, 0, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, 3 * TICK, 0, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, -TICK, 0, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, -20 * TICK, 0, 0, 1, 0, ST_BEYOND);
		add_row(0, REQ_INSERT, 15 * TICK, 64'h0C, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, 14 * TICK, 0, 0, 0, 0, ST_OK);
		// Narrowest nonzero span.
		add_row(1, REQ_INSERT, 0, 1, 0, 0, 0, ST_OK);
		add_row(0, REQ_INSERT, TIME_TOP - 1, 64'h0D, 0, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TIME_BOTTOM, 0, TIME_BOTTOM, 0, 0, ST_OK);
		add_row(0, REQ_LOOKBACK, TIME_TOP - 1, 0, 0, 0, 0, ST_OK);

		// Random phases: a span that keeps the store overflowing, a moderate one, the
		// widest, the narrowest, a random one, a short one, inserts switched off, and a
		// closing phase with no idling on either side.
		phase_span = '{200 * TICK, 20 * TICK, SPAN_ALL, 1,
			longint'(rand64() & 64'h0000_7FFF_FFFF_FFFF), 5 * TICK, 0, 64 * TICK};
		phase_gap = '{10, 0, 30, 10, 0, 30, 10, 0};
		phase_stall = '{5, 0, 12, 5, 0, 12, 5, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 10;
		stall_pct = 5;
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_span(longint'(plan[i].w.sval));
			else
				send_word(plan[i].w, plan[i].typed, plan[i].ans);
		end

		clock_cur = longint'($urandom_range(0, 1023)) * TICK;
		for (p = 0; p < phase_span.size(); p++) begin
			write_span(phase_span[p]);
			gap_pct = phase_gap[p];
			stall_pct = phase_stall[p];
			phase_items = (phase_span[p] == 0) ? 60 : 170;
			for (i = 0; i < phase_items; i++)
				send_word(compose_word(), 1'b0, none);
		end

		in_valid <= 1'b0;
		while (n_out < n_sent)
			@(posedge clk);
		// A little longer, so a stray extra result would still be caught.
		repeat (20) @(posedge clk);
		if (answers_due.size() != 0) begin
			mismatches += answers_due.size();
			$display("%0d result words never arrived", answers_due.size());
		end

		$display("%0d words (%0d inserts, %0d lookbacks) under %0d window-span settings",
			n_sent, n_ins, n_look, span_writes);
		$display("status seen: ok %0d beyond %0d empty %0d disabled %0d duplicate %0d "
			, st_tally[ST_OK], st_tally[ST_BEYOND], st_tally[ST_EMPTY],
			st_tally[ST_DISABLED], st_tally[ST_DUPLICATE], "dropped %0d",
			st_tally[ST_DROPPED]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/twhl_pkg.sv
src/twhl_cell.sv
src/time_window_history_lookback_unit.sv
bench/tb_time_window_history_lookback_unit.sv
